// ----- hdl/key_group_batch_layout_top_assert.svh -----
// Assertion macros used by key_group_batch_layout_top.
`ifndef KEY_GROUP_BATCH_LAYOUT_TOP_ASSERT_SVH
`define KEY_GROUP_BATCH_LAYOUT_TOP_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define KGB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kgb implication check failed");

// Condition that must never be seen outside reset.
`define KGB_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("kgb forbidden condition seen");

`endif

// ----- hdl/kgb_pkg.sv -----
`timescale 1ns / 1ps

package kgb_pkg;

    // Default sizes
    localparam int MAX_ITEMS_DEF   = 1024;
    localparam int MAX_GROUPS_DEF  = 64;
    localparam int MAP_ENTRIES_DEF = 128;
    localparam int BLOCK_ITEMS_DEF = 16;

    // Hash constants
    localparam logic [31:0] HASH_MUL     = 32'd2654435761;
    localparam int          HASH_SHIFT   = 22;
    localparam int          HASH_W       = 32 - HASH_SHIFT;
    localparam logic [31:0] RESERVED_KEY = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        MD_ADD    = 2'd0,
        MD_FINISH = 2'd1,
        MD_GROUP  = 2'd2,
        MD_SLOT   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_GCAP  = 3'd2,
        ST_BAD   = 3'd3,
        ST_EMPTY = 3'd4
    } t_status;

    // Per-request result fields, totals are added when the result is posted
    typedef struct packed {
        t_status     status;
        logic [31:0] group_key;
        logic [10:0] first_pos;
        logic [10:0] span_len;
        logic [10:0] item_len;
        logic [6:0]  blk_base;
        logic [9:0]  source_index;
        logic        is_padding;
    } t_res;

endpackage

// ----- hdl/kgb_hash.sv -----
`timescale 1ns / 1ps

// Multiplicative hash, then reduction into the map by repeated subtraction.
module kgb_hash #(
    parameter int MAP_ENTRIES = kgb_pkg::MAP_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [31:0]                    i_key,
    output logic                           o_done,
    output logic [$clog2(MAP_ENTRIES)-1:0] o_idx
);

    localparam int MAW = $clog2(MAP_ENTRIES);
    localparam int HW  = kgb_pkg::HASH_W;

    typedef enum logic [1:0] {H_IDLE, H_MUL, H_MOD} t_hstate;

    t_hstate        r_state;
    logic [31:0]    r_prod;
    logic [HW-1:0]  r_h;
    logic           ge;

    assign ge     = (HW+1)'(r_h) >= (HW+1)'(MAP_ENTRIES);
    assign o_done = (r_state == H_MOD) && !ge;
    assign o_idx  = MAW'(r_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
        end else begin
            case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_prod  <= 32'(i_key * kgb_pkg::HASH_MUL);
                        r_state <= H_MUL;
                    end
                end
                H_MUL: begin
                    r_h     <= HW'(r_prod >> kgb_pkg::HASH_SHIFT);
                    r_state <= H_MOD;
                end
                H_MOD: begin
                    // one subtraction per cycle until below the map size
                    if (ge) r_h <= r_h - HW'(MAP_ENTRIES);
                    else    r_state <= H_IDLE;
                end
                default: r_state <= H_IDLE;
            endcase
        end
    end

endmodule

// ----- hdl/key_group_batch_layout_top.sv -----
`timescale 1ns / 1ps
// Reads post after a registered table read; rejected requests post directly.
// A key load hashes, reduces and probes the map linearly; an existing key also
// bumps its group count. Finish ranks each group against all, pads groups to whole
// blocks in rank order, then gathers items; one read port per table, one sequencer.
// Throughput: one request at a time; o_stall is high until the result is posted.
// Reset: synchronous active low; clears state, flags, counts, totals; not tables.
module key_group_batch_layout_top #(
    parameter int MAX_ITEMS   = kgb_pkg::MAX_ITEMS_DEF,
    parameter int MAX_GROUPS  = kgb_pkg::MAX_GROUPS_DEF,
    parameter int MAP_ENTRIES = kgb_pkg::MAP_ENTRIES_DEF,
    parameter int BLOCK_ITEMS = kgb_pkg::BLOCK_ITEMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_key,
    input  logic [10:0] i_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_group_key,
    output logic [10:0] o_first_pos,
    output logic [10:0] o_span_len,
    output logic [10:0] o_item_len,
    output logic [6:0]  o_blk_base,
    output logic [9:0]  o_source_index,
    output logic        o_is_padding,
    output logic [6:0]  o_group_total,
    output logic [7:0]  o_block_total
);

    localparam int IAW        = $clog2(MAX_ITEMS);
    localparam int CW         = $clog2(MAX_ITEMS + 1);
    localparam int GAW        = $clog2(MAX_GROUPS);
    localparam int GCW        = $clog2(MAX_GROUPS + 1);
    localparam int MAW        = $clog2(MAP_ENTRIES);
    localparam int SLOT_DEPTH = MAX_ITEMS + MAX_GROUPS * (BLOCK_ITEMS - 1);
    localparam int SAW        = $clog2(SLOT_DEPTH);
    localparam int SW         = $clog2(SLOT_DEPTH + 1);
    localparam int BW         = $clog2(SLOT_DEPTH / BLOCK_ITEMS + 1);

    typedef struct packed {
        logic [31:0]   key;
        logic [SW-1:0] first;
        logic [SW-1:0] padded;
        logic [CW-1:0] count;
        logic [BW-1:0] blk;
    } t_desc;

    typedef enum logic [4:0] {
        S_IDLE, S_HASH, S_PRD, S_PCHK, S_CRD, S_CINC,
        S_RK_A, S_RK_B, S_RK_C, S_RK_D,
        S_LY_A, S_LY_B, S_LY_C, S_LY_D, S_LY_P, S_LY_W,
        S_IT_A, S_IT_B, S_IT_C, S_IT_D, S_IT_E, S_IT_F,
        S_GRD, S_GUSE, S_SRD, S_SUSE, S_DONE
    } t_state;

    // Tables
    logic [31:0]    r_map_key  [MAP_ENTRIES];
    logic [GAW-1:0] r_map_grp  [MAP_ENTRIES];
    logic [31:0]    r_grp_key  [MAX_GROUPS];
    logic [CW-1:0]  r_grp_cnt  [MAX_GROUPS];
    logic [GAW-1:0] r_grp_rank [MAX_GROUPS];
    logic [GAW-1:0] r_rank_grp [MAX_GROUPS];
    logic [SW-1:0]  r_cursor   [MAX_GROUPS];
    t_desc          r_desc     [MAX_GROUPS];
    logic [GAW-1:0] r_item_grp [MAX_ITEMS];
    logic [IAW:0]   r_slot     [SLOT_DEPTH];

    // Registered read data
    logic [31:0]    r_map_key_rd, r_grp_key_rd;
    logic [GAW-1:0] r_map_grp_rd, r_grp_rank_rd, r_rank_grp_rd, r_item_grp_rd;
    logic [CW-1:0]  r_grp_cnt_rd;
    logic [SW-1:0]  r_cursor_rd;
    t_desc          r_desc_rd;
    logic [IAW:0]   r_slot_rd;

    // Control and working registers
    t_state                 r_state;
    logic [MAP_ENTRIES-1:0] r_mvalid;
    logic [CW-1:0]          r_icnt;
    logic [GCW-1:0]         r_gcnt;
    logic                   r_built;
    logic [SW-1:0]          r_totpos;
    logic [BW-1:0]          r_totblk;
    logic [31:0]            r_key, r_kg;
    logic [MAW-1:0]         r_mi, r_probe;
    logic [GAW-1:0]         r_g, r_h, r_r, r_rk;
    logic [CW-1:0]          r_cnt;
    logic [SW-1:0]          r_pad, r_pos, r_p;
    logic [BW-1:0]          r_nb, r_blk;
    logic [IAW-1:0]         r_j;
    kgb_pkg::t_res          r_res;
    logic                   r_ovalid;
    kgb_pkg::t_res          r_ores;
    logic [6:0]             r_ogt;
    logic [7:0]             r_obt;

    logic           accept, hash_go, hash_done, full_now, lt, last_h, last_g, last_r, last_j;
    logic           create, inc, rk_wr, ly_wr, pad_wr, it_wr, pad_more;
    logic [MAW-1:0] hash_idx;
    logic [GAW-1:0] n_rk;
    logic [CW-1:0]  eff_icnt;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign eff_icnt = r_built ? '0 : r_icnt;
    assign full_now = eff_icnt >= CW'(MAX_ITEMS);
    assign hash_go  = accept && (i_mode == kgb_pkg::MD_ADD)
                   && (i_key != kgb_pkg::RESERVED_KEY) && !full_now;

    kgb_hash #(.MAP_ENTRIES(MAP_ENTRIES)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_go),
        .i_key   (i_key),
        .o_done  (hash_done),
        .o_idx   (hash_idx)
    );

    // Shared compare and loop-end conditions
    assign lt       = r_grp_key_rd < r_kg;
    assign n_rk     = r_rk + GAW'(lt);
    assign last_h   = (GCW'(r_h) + GCW'(1)) == r_gcnt;
    assign last_g   = (GCW'(r_g) + GCW'(1)) == r_gcnt;
    assign last_r   = (GCW'(r_r) + GCW'(1)) == r_gcnt;
    assign last_j   = (CW'(r_j) + CW'(1)) == r_icnt;
    assign pad_more = r_p < (r_pos + r_pad);

    assign create = (r_state == S_PCHK) && !r_mvalid[r_mi] && (r_gcnt < GCW'(MAX_GROUPS));
    assign inc    = (r_state == S_CINC);
    assign rk_wr  = (r_state == S_RK_D) && last_h;
    assign ly_wr  = (r_state == S_LY_P) && !(r_pad < SW'(r_cnt));
    assign pad_wr = (r_state == S_LY_W) && pad_more;
    assign it_wr  = (r_state == S_IT_F);

    // Hash map
    always_ff @(posedge i_clk) begin
        if (create) begin
            r_map_key[r_mi] <= r_key;
            r_map_grp[r_mi] <= GAW'(r_gcnt);
        end
        r_map_key_rd <= r_map_key[r_mi];
        r_map_grp_rd <= r_map_grp[r_mi];
    end

    // Group keys
    always_ff @(posedge i_clk) begin
        if (create) r_grp_key[GAW'(r_gcnt)] <= r_key;
        r_grp_key_rd <= r_grp_key[(r_state == S_RK_C) ? r_h : r_g];
    end

    // Group counts
    always_ff @(posedge i_clk) begin
        if (create)   r_grp_cnt[GAW'(r_gcnt)] <= CW'(1);
        else if (inc) r_grp_cnt[r_g] <= r_grp_cnt_rd + CW'(1);
        r_grp_cnt_rd <= r_grp_cnt[r_g];
    end

    // Rank tables
    always_ff @(posedge i_clk) begin
        if (rk_wr) begin
            r_grp_rank[r_g]  <= n_rk;
            r_rank_grp[n_rk] <= r_g;
        end
        r_grp_rank_rd <= r_grp_rank[r_g];
        r_rank_grp_rd <= r_rank_grp[r_r];
    end

    // Gather cursors and group descriptors, by rank
    always_ff @(posedge i_clk) begin
        if (ly_wr)      r_cursor[r_r] <= r_pos;
        else if (it_wr) r_cursor[r_r] <= r_cursor_rd + SW'(1);
        if (ly_wr) r_desc[r_r] <= '{key: r_kg, first: r_pos, padded: r_pad,
                                    count: r_cnt, blk: r_blk};
        r_cursor_rd <= r_cursor[r_r];
        r_desc_rd   <= r_desc[r_r];
    end

    // Group of each loaded item
    always_ff @(posedge i_clk) begin
        if (create)   r_item_grp[r_icnt[IAW-1:0]] <= GAW'(r_gcnt);
        else if (inc) r_item_grp[r_icnt[IAW-1:0]] <= r_g;
        r_item_grp_rd <= r_item_grp[r_j];
    end

    // Sorted slots: pad flag over source index
    always_ff @(posedge i_clk) begin
        if (pad_wr)     r_slot[SAW'(r_p)] <= {1'b1, {IAW{1'b0}}};
        else if (it_wr) r_slot[SAW'(r_cursor_rd)] <= {1'b0, r_j};
        r_slot_rd <= r_slot[SAW'(r_p)];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mvalid <= '0;
            r_icnt   <= '0;
            r_gcnt   <= '0;
            r_built  <= 1'b0;
            r_totpos <= '0;
            r_totblk <= '0;
            r_ovalid <= 1'b0;
            r_res    <= '0;
        end else begin
            if (r_ovalid && !i_stall && (r_state != S_DONE)) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_key <= i_key;
                        case (i_mode)
                            kgb_pkg::MD_ADD: begin
                                // a load after finish starts a new batch
                                if (r_built) begin
                                    r_mvalid <= '0;
                                    r_icnt   <= '0;
                                    r_gcnt   <= '0;
                                    r_built  <= 1'b0;
                                    r_totpos <= '0;
                                    r_totblk <= '0;
                                end
                                if (i_key == kgb_pkg::RESERVED_KEY) begin
                                    r_res.status <= kgb_pkg::ST_BAD;
                                    r_state      <= S_DONE;
                                end else if (full_now) begin
                                    r_res.status <= kgb_pkg::ST_FULL;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_state <= S_HASH;
                                end
                            end
                            kgb_pkg::MD_FINISH: begin
                                if (r_icnt == '0) begin
                                    r_built      <= 1'b0;
                                    r_res.status <= kgb_pkg::ST_EMPTY;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_g     <= '0;
                                    r_state <= S_RK_A;
                                end
                            end
                            kgb_pkg::MD_GROUP: begin
                                if (!r_built || (12'(i_index) >= 12'(r_gcnt))) begin
                                    r_res.status <= kgb_pkg::ST_BAD;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_r     <= GAW'(i_index);
                                    r_state <= S_GRD;
                                end
                            end
                            default: begin
                                if (!r_built || (32'(i_index) >= 32'(r_totpos))) begin
                                    r_res.status <= kgb_pkg::ST_BAD;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_p     <= SW'(i_index);
                                    r_state <= S_SRD;
                                end
                            end
                        endcase
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        r_mi    <= hash_idx;
                        r_probe <= '0;
                        r_state <= S_PRD;
                    end
                end
                S_PRD: r_state <= S_PCHK;
                // linear probe step
                S_PCHK: begin
                    if (!r_mvalid[r_mi]) begin
                        if (create) begin
                            r_mvalid[r_mi] <= 1'b1;
                            r_gcnt         <= r_gcnt + GCW'(1);
                            r_icnt         <= r_icnt + CW'(1);
                        end else begin
                            r_res.status <= kgb_pkg::ST_GCAP;
                        end
                        r_state <= S_DONE;
                    end else if (r_map_key_rd == r_key) begin
                        r_g     <= r_map_grp_rd;
                        r_state <= S_CRD;
                    end else if (r_probe == MAW'(MAP_ENTRIES - 1)) begin
                        r_res.status <= kgb_pkg::ST_GCAP;
                        r_state      <= S_DONE;
                    end else begin
                        r_mi    <= (r_mi == MAW'(MAP_ENTRIES - 1)) ? '0 : r_mi + MAW'(1);
                        r_probe <= r_probe + MAW'(1);
                        r_state <= S_PRD;
                    end
                end
                S_CRD: r_state <= S_CINC;
                S_CINC: begin
                    r_icnt  <= r_icnt + CW'(1);
                    r_state <= S_DONE;
                end
                // rank of a group = number of groups with a smaller key
                S_RK_A: r_state <= S_RK_B;
                S_RK_B: begin
                    r_kg    <= r_grp_key_rd;
                    r_h     <= '0;
                    r_rk    <= '0;
                    r_state <= S_RK_C;
                end
                S_RK_C: r_state <= S_RK_D;
                S_RK_D: begin
                    r_rk <= n_rk;
                    if (!last_h) begin
                        r_h     <= r_h + GAW'(1);
                        r_state <= S_RK_C;
                    end else if (!last_g) begin
                        r_g     <= r_g + GAW'(1);
                        r_state <= S_RK_A;
                    end else begin
                        r_r     <= '0;
                        r_pos   <= '0;
                        r_blk   <= '0;
                        r_state <= S_LY_A;
                    end
                end
                // layout walk in rank order
                S_LY_A: r_state <= S_LY_B;
                S_LY_B: begin
                    r_g     <= r_rank_grp_rd;
                    r_state <= S_LY_C;
                end
                S_LY_C: r_state <= S_LY_D;
                S_LY_D: begin
                    r_cnt   <= r_grp_cnt_rd;
                    r_kg    <= r_grp_key_rd;
                    r_pad   <= '0;
                    r_nb    <= '0;
                    r_state <= S_LY_P;
                end
                S_LY_P: begin
                    // round up to whole blocks, one block per cycle
                    if (r_pad < SW'(r_cnt)) begin
                        r_pad <= r_pad + SW'(BLOCK_ITEMS);
                        r_nb  <= r_nb + BW'(1);
                    end else begin
                        r_p     <= r_pos + SW'(r_cnt);
                        r_state <= S_LY_W;
                    end
                end
                S_LY_W: begin
                    if (pad_more) begin
                        r_p <= r_p + SW'(1);
                    end else begin
                        r_pos <= r_pos + r_pad;
                        r_blk <= r_blk + r_nb;
                        if (last_r) begin
                            r_j     <= '0;
                            r_state <= S_IT_A;
                        end else begin
                            r_r     <= r_r + GAW'(1);
                            r_state <= S_LY_A;
                        end
                    end
                end
                // gather items in load order
                S_IT_A: r_state <= S_IT_B;
                S_IT_B: begin
                    r_g     <= r_item_grp_rd;
                    r_state <= S_IT_C;
                end
                S_IT_C: r_state <= S_IT_D;
                S_IT_D: begin
                    r_r     <= r_grp_rank_rd;
                    r_state <= S_IT_E;
                end
                S_IT_E: r_state <= S_IT_F;
                S_IT_F: begin
                    if (last_j) begin
                        r_built  <= 1'b1;
                        r_totpos <= r_pos;
                        r_totblk <= r_blk;
                        r_state  <= S_DONE;
                    end else begin
                        r_j     <= r_j + IAW'(1);
                        r_state <= S_IT_A;
                    end
                end
                S_GRD: r_state <= S_GUSE;
                S_GUSE: begin
                    r_res.group_key    <= r_desc_rd.key;
                    r_res.first_pos    <= 11'(r_desc_rd.first);
                    r_res.span_len     <= 11'(r_desc_rd.padded);
                    r_res.item_len     <= 11'(r_desc_rd.count);
                    r_res.blk_base     <= 7'(r_desc_rd.blk);
                    r_state            <= S_DONE;
                end
                S_SRD: r_state <= S_SUSE;
                S_SUSE: begin
                    r_res.is_padding <= r_slot_rd[IAW];
                    if (!r_slot_rd[IAW]) r_res.source_index <= 10'(r_slot_rd[IAW-1:0]);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // post the result once the output register is free
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_ores   <= r_res;
                        r_res    <= '0;
                        r_ogt    <= 7'(r_gcnt);
                        r_obt    <= r_built ? 8'(r_totblk) : 8'd0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_ores.status;
    assign o_group_key    = r_ores.group_key;
    assign o_first_pos    = r_ores.first_pos;
    assign o_span_len     = r_ores.span_len;
    assign o_item_len     = r_ores.item_len;
    assign o_blk_base     = r_ores.blk_base;
    assign o_source_index = r_ores.source_index;
    assign o_is_padding   = r_ores.is_padding;
    assign o_group_total  = r_ogt;
    assign o_block_total  = r_obt;

`include "key_group_batch_layout_top_assert.svh"

    `KGB_ASSERT_NEVER(a_gcnt_cap, r_gcnt > GCW'(MAX_GROUPS))
    `KGB_ASSERT_IMPL(a_built_has_items, r_built, r_icnt != '0)
    `KGB_ASSERT_IMPL(a_hash_in_wait, hash_done, r_state == S_HASH)

endmodule
